### src/srl_pkg.sv
// Shared types and constants for the stereo linear resampler.
// Used by the channel interfaces, the controller, the datapath and the top level.
package srl_pkg;

   // Default fraction width of the phase and the step
   localparam int FRAC_BITS_DEF = 16;
   // Default cap on results per input word
   localparam int MAX_RUN_DEF   = 8;

   // Fixed sample width of both channels
   localparam int SAMPLE_W = 16;

   // Register port geometry
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Register indexes
   localparam logic REG_PHASE_STEP = 1'b0;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;     // take the input word, apply restart
      logic mul;      // form both products, decide run_last
      logic add;      // form both results, advance the phase
      logic commit;   // retire the word: update phase and history
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic run_more; // phase below one and run cap not reached
   } status_type;

endpackage

### src/srl_req_if.sv
// Input channel of the stereo linear resampler: one stereo frame per word.
// Depends on srl_pkg for the sample type.
interface srl_req_if;
   logic                valid;
   logic                ready;
   srl_pkg::sample_type left_sample;
   srl_pkg::sample_type right_sample;
   logic                restart;

   modport source (output valid, output left_sample, output right_sample,
                   output restart, input ready);
   modport sink   (input valid, input left_sample, input right_sample,
                   input restart, output ready);
endinterface

### src/srl_rsp_if.sv
// Result channel of the stereo linear resampler: one interpolated frame per word.
// Depends on srl_pkg for the sample type.
interface srl_rsp_if;
   logic                valid;
   logic                ready;
   srl_pkg::sample_type left_out;
   srl_pkg::sample_type right_out;
   logic                run_last;

   modport source (output valid, output left_out, output right_out,
                   output run_last, input ready);
   modport sink   (input valid, input left_out, input right_out,
                   input run_last, output ready);
endinterface

### src/stereo_linear_resampler.sv
// Stereo linear resampler: each input word (one stereo frame) yields zero to MAX_RUN
// interpolated frames prev + floor(phase * (cur - prev)), with the phase advancing by the
// phase_step register (input rate over output rate, unsigned Q2.FRAC_BITS, reset to one).
// One word is worked at a time: it is accepted in IDLE, then each result passes through a
// phase test, product, sum and hand-off, the hand-off holding while rsp waits on ready, and
// a final phase test retires the word. A single pair of sample multipliers is shared in
// turn by the results of a word.
// Write phase_step at byte address 0 only while no word is in flight.
module stereo_linear_resampler #(
   parameter int FRAC_BITS = srl_pkg::FRAC_BITS_DEF,
   parameter int MAX_RUN   = srl_pkg::MAX_RUN_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   srl_req_if.sink                         req,
   srl_rsp_if.source                       rsp,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [srl_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [srl_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [srl_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);

   localparam int AW = FRAC_BITS + 2;

   logic [AW-1:0]       phase_step_ff;
   logic                csr_sel_step;
   srl_pkg::cmd_type    cmd;
   srl_pkg::status_type status;

   // Register decode
   assign csr_pready   = 1'b1;
   assign csr_sel_step = (csr_paddr[2] == srl_pkg::REG_PHASE_STEP);
   assign csr_prdata   = csr_sel_step ? srl_pkg::CSR_DATA_W'(phase_step_ff) : '0;

   // Hold the step, take writes on the access cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff <= AW'(1) << FRAC_BITS;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_sel_step) begin
         phase_step_ff <= csr_pwdata[AW-1:0];
      end
   end

   srl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .status    (status),
      .cmd       (cmd)
   );

   srl_dp #(
      .FRAC_BITS (FRAC_BITS),
      .MAX_RUN   (MAX_RUN)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .phase_step   (phase_step_ff),
      .left_sample  (req.left_sample),
      .right_sample (req.right_sample),
      .restart      (req.restart),
      .left_out     (rsp.left_out),
      .right_out    (rsp.right_out),
      .run_last     (rsp.run_last)
   );

`ifndef SYNTH
   // Never take a new word while a result is still offered
   assert property (@(posedge clock) disable iff (reset) !(req.ready && rsp.valid))
      else $error("input taken while a result is pending");

   // Close the input right after a word is taken
   assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> !req.ready)
      else $error("input still open after a word was taken");

   // Offer nothing in the cycle after the final result of a run
   assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.ready && rsp.run_last) |=> !rsp.valid)
      else $error("result offered after the final one of a run");
`endif

endmodule

### src/srl_ctrl.sv
// Sequencer of the stereo linear resampler: walks one input word through its results.
// Depends on srl_pkg for the command and status structs.
module srl_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  srl_pkg::status_type  status,
   output srl_pkg::cmd_type     cmd
);

   typedef enum logic [2:0] {
      IDLE,
      CHECK,
      MUL,
      ADD,
      SEND
   } state_type;

   state_type state_ff, state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         IDLE:  if (req_valid) state_in = CHECK;
         CHECK: state_in = status.run_more ? MUL : IDLE;
         MUL:   state_in = ADD;
         ADD:   state_in = SEND;
         SEND:  if (rsp_ready) state_in = CHECK;
         default: state_in = IDLE;
      endcase
   end

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == IDLE);
   assign rsp_valid = (state_ff == SEND);

   // Issue datapath commands
   always_comb begin
      cmd        = '0;
      cmd.load   = (state_ff == IDLE) && req_valid;
      cmd.mul    = (state_ff == MUL);
      cmd.add    = (state_ff == ADD);
      cmd.commit = (state_ff == CHECK) && !status.run_more;
   end

endmodule

### src/srl_dp.sv
// Datapath of the stereo linear resampler: phase, history, products and result registers.
// Depends on srl_pkg for the sample type and the command and status structs.
module srl_dp #(
   parameter int FRAC_BITS = srl_pkg::FRAC_BITS_DEF,
   parameter int MAX_RUN   = srl_pkg::MAX_RUN_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  srl_pkg::cmd_type      cmd,
   output srl_pkg::status_type   status,
   input  logic [FRAC_BITS+1:0]  phase_step,
   input  srl_pkg::sample_type   left_sample,
   input  srl_pkg::sample_type   right_sample,
   input  logic                  restart,
   output srl_pkg::sample_type   left_out,
   output srl_pkg::sample_type   right_out,
   output logic                  run_last
);

   localparam int SW    = srl_pkg::SAMPLE_W;
   localparam int AW    = FRAC_BITS + 2;           // stored phase
   localparam int PW    = FRAC_BITS + 3;           // running phase, holds phase + step
   localparam int DW    = SW + 1;                  // sample difference
   localparam int MW    = DW + FRAC_BITS + 1;      // signed product
   localparam int CW    = $clog2(MAX_RUN + 1);
   localparam logic [PW-1:0] PH_ONE  = PW'(1) << FRAC_BITS;
   localparam logic [CW-1:0] RUN_CAP = CW'(MAX_RUN);

   logic [AW-1:0]      phase_acc_ff;
   logic [PW-1:0]      ph_ff;
   logic [CW-1:0]      cnt_ff;
   logic signed [SW-1:0] hist_l_ff, hist_r_ff;
   logic signed [SW-1:0] cur_l_ff, cur_r_ff;
   logic signed [MW-1:0] prod_l_ff, prod_r_ff;
   logic signed [SW-1:0] out_l_ff, out_r_ff;
   logic               last_ff;

   logic signed [DW-1:0] diff_l, diff_r;
   logic signed [MW-1:0] frac_ext, prod_l_in, prod_r_in;
   logic signed [DW-1:0] quot_l, quot_r;
   logic signed [DW-1:0] sum_l, sum_r;
   logic [PW-1:0]      ph_sum;
   logic [CW-1:0]      cnt_nx;
   logic               last_in;
   logic [AW-1:0]      phase_acc_in;

   // Differences and products of both channels
   assign diff_l    = {cur_l_ff[SW-1], cur_l_ff} - {hist_l_ff[SW-1], hist_l_ff};
   assign diff_r    = {cur_r_ff[SW-1], cur_r_ff} - {hist_r_ff[SW-1], hist_r_ff};
   assign frac_ext  = $signed({{(MW-FRAC_BITS){1'b0}}, ph_ff[FRAC_BITS-1:0]});
   assign prod_l_in = $signed({{(MW-DW){diff_l[DW-1]}}, diff_l}) * frac_ext;
   assign prod_r_in = $signed({{(MW-DW){diff_r[DW-1]}}, diff_r}) * frac_ext;

   // Floor of product over one, then offset by the history sample
   assign quot_l = prod_l_ff[FRAC_BITS+DW-1:FRAC_BITS];
   assign quot_r = prod_r_ff[FRAC_BITS+DW-1:FRAC_BITS];
   assign sum_l  = {hist_l_ff[SW-1], hist_l_ff} + quot_l;
   assign sum_r  = {hist_r_ff[SW-1], hist_r_ff} + quot_r;

   // Look one step ahead to mark the final result of the run
   assign ph_sum  = ph_ff + {1'b0, phase_step};
   assign cnt_nx  = cnt_ff + CW'(1);
   assign last_in = !((ph_sum < PH_ONE) && (cnt_nx < RUN_CAP));

   // Drop one from the phase, or clear it when the run cap cut the loop
   assign phase_acc_in = (ph_ff >= PH_ONE) ? AW'(ph_ff - PH_ONE) : '0;

   assign status.run_more = (ph_ff < PH_ONE) && (cnt_ff < RUN_CAP);

   // Stored state: phase and previous frame
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_acc_ff <= '0;
         hist_l_ff    <= '0;
         hist_r_ff    <= '0;
      end else if (cmd.load && restart) begin
         phase_acc_ff <= '0;
         hist_l_ff    <= '0;
         hist_r_ff    <= '0;
      end else if (cmd.commit) begin
         phase_acc_ff <= phase_acc_in;
         hist_l_ff    <= cur_l_ff;
         hist_r_ff    <= cur_r_ff;
      end
   end

   // Run counter
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.load) begin
         cnt_ff <= '0;
      end else if (cmd.add) begin
         cnt_ff <= cnt_nx;
      end
   end

   // Word payload, running phase, products and results
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cur_l_ff <= left_sample;
         cur_r_ff <= right_sample;
         ph_ff    <= restart ? '0 : {1'b0, phase_acc_ff};
      end else if (cmd.add) begin
         ph_ff    <= ph_sum;
      end
      if (cmd.mul) begin
         prod_l_ff <= prod_l_in;
         prod_r_ff <= prod_r_in;
         last_ff   <= last_in;
      end
      if (cmd.add) begin
         out_l_ff <= sum_l[SW-1:0];
         out_r_ff <= sum_r[SW-1:0];
      end
   end

   assign left_out  = out_l_ff;
   assign right_out = out_r_ff;
   assign run_last  = last_ff;

endmodule

### dv/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for stereo_linear_resampler: frames in, interpolated frames out.
// Depends on srl_pkg and the srl_req_if / srl_rsp_if channel interfaces.
module testbench;

   localparam int FRAC      = srl_pkg::FRAC_BITS_DEF;
   localparam int RUN_CAP   = srl_pkg::MAX_RUN_DEF;
   localparam int STEP_W    = FRAC + 2;
   localparam logic [31:0] PHASE_ONE = 32'(1) << FRAC;
   localparam logic [srl_pkg::CSR_ADDR_W-1:0] STEP_ADDR  =
      srl_pkg::CSR_ADDR_W'({srl_pkg::REG_PHASE_STEP, 2'b00});
   localparam logic [srl_pkg::CSR_ADDR_W-1:0] SPARE_ADDR = srl_pkg::CSR_ADDR_W'(4);
   localparam srl_pkg::sample_type S_MAX = 16'sh7fff;
   localparam srl_pkg::sample_type S_MIN = 16'sh8000;
   localparam int IDLE_TAIL     = 16;
   localparam int RANDOM_FRAMES = 160;
   localparam int PHASE_LEN     = 20;

   typedef struct packed {
      srl_pkg::sample_type left;
      srl_pkg::sample_type right;
      logic                last;
   } out_frame_type;

   typedef enum logic [1:0] {ROW_TYPED, ROW_FRAME, ROW_WRITE} row_kind_type;

   typedef struct packed {
      row_kind_type                     kind;
      logic [31:0]                      data;
      logic [srl_pkg::CSR_ADDR_W-1:0]   addr;
      srl_pkg::sample_type              left;
      srl_pkg::sample_type              right;
      logic                             restart;
      srl_pkg::sample_type              exp_left;
      srl_pkg::sample_type              exp_right;
   } row_type;

   logic clock;
   logic reset;
   logic                            csr_psel;
   logic                            csr_penable;
   logic                            csr_pwrite;
   logic [srl_pkg::CSR_ADDR_W-1:0]  csr_paddr;
   logic [srl_pkg::CSR_DATA_W-1:0]  csr_pwdata;
   logic [srl_pkg::CSR_DATA_W-1:0]  csr_prdata;
   logic                            csr_pready;

   srl_req_if req_if();
   srl_rsp_if rsp_if();

   stereo_linear_resampler u_top (
      .clock       (clock),
      .reset       (reset),
      .req         (req_if),
      .rsp         (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Resampler state as the bench sees it
   logic [STEP_W-1:0]   model_step;
   logic [STEP_W-1:0]   model_phase;
   srl_pkg::sample_type model_hist_l;
   srl_pkg::sample_type model_hist_r;

   out_frame_type pending[$];
   int  errors;
   int  words_in;
   int  words_out;
   int  restarts;
   int  step_writes;
   int  predicted;
   bit  sender_calm;
   bit  sink_calm;

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // prev + floor(ph * (cur - prev) / 2^FRAC), exact in 64 bits
   function automatic srl_pkg::sample_type blend(srl_pkg::sample_type prev,
                                                 srl_pkg::sample_type cur,
                                                 logic [31:0] ph);
      longint span;
      longint full;
      span = longint'(cur) - longint'(prev);
      full = longint'(prev) + ((span * longint'(ph)) >>> FRAC);
      return srl_pkg::sample_type'(full);
   endfunction

   // Advance the phase across one input word, queue the frames it yields
   task automatic resample(input srl_pkg::sample_type cur_l, input srl_pkg::sample_type cur_r,
                           input logic restart, input bit record);
      logic [31:0]    ph;
      int             n;
      out_frame_type  run_q[$];
      out_frame_type  f;
      if (restart) begin
         model_phase  = '0;
         model_hist_l = '0;
         model_hist_r = '0;
      end
      ph = 32'(model_phase);
      n  = 0;
      while (ph < PHASE_ONE && n < RUN_CAP) begin
         f.left  = blend(model_hist_l, cur_l, ph);
         f.right = blend(model_hist_r, cur_r, ph);
         f.last  = 1'b0;
         run_q.push_back(f);
         n++;
         ph += 32'(model_step);
      end
      // run cap hit below one clears the phase instead of wrapping it
      if (ph >= PHASE_ONE) model_phase = STEP_W'(ph - PHASE_ONE);
      else                 model_phase = '0;
      model_hist_l = cur_l;
      model_hist_r = cur_r;
      predicted += n;
      if (record) begin
         foreach (run_q[i]) begin
            f = run_q[i];
            f.last = (i == n - 1);
            pending.push_back(f);
         end
      end
   endtask

   // Offer one word on req after a random gap, hold until taken
   task automatic push_word(input srl_pkg::sample_type l, input srl_pkg::sample_type r,
                            input logic restart, input bit record);
      int gap;
      gap = sender_calm ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.left_sample  <= l;
      req_if.right_sample <= r;
      req_if.restart      <= restart;
      do @(posedge clock); while (!req_if.ready);
      words_in++;
      if (restart) restarts++;
      resample(l, r, restart, record);
   endtask

   // Drop valid and wait until every expected word is back and the block is quiet
   task automatic settle();
      req_if.valid <= 1'b0;
      while (pending.size() != 0) @(posedge clock);
      repeat (IDLE_TAIL) @(posedge clock);
   endtask

   task automatic csr_write(input logic [srl_pkg::CSR_ADDR_W-1:0] addr,
                            input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      if (addr == STEP_ADDR) model_step = data[STEP_W-1:0];
      step_writes++;
   endtask

   // Read phase_step back and compare with the bench copy
   task automatic csr_check_step();
      logic [31:0] got;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= STEP_ADDR;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      got = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      if (got !== 32'(model_step)) begin
         $display("%0t: phase_step read expected %0h got %0h", $time, model_step, got);
         errors++;
      end
   endtask

   // Random sample with extra weight on the rails and near zero
   function automatic srl_pkg::sample_type pick_sample();
      case ($urandom_range(0, 7))
         0:       return S_MAX;
         1:       return S_MIN;
         2:       return srl_pkg::sample_type'($urandom_range(0, 64)) - 16'sd32;
         default: return srl_pkg::sample_type'($urandom);
      endcase
   endfunction

   function automatic logic [31:0] pick_step(int phase_no);
      case (phase_no)
         0: return 32'h3ffff;
         1: return 32'd8192;
         2: return 32'd0;
         default: begin
            case ($urandom_range(0, 9))
               0, 1:    return $urandom_range(8192, 262143);
               2, 3, 4: return $urandom_range(8192, 98304);
               5:       return $urandom_range(0, 8191);
               6:       return PHASE_ONE;
               7:       return $urandom;
               8:       return 32'h3ffff;
               default: return 32'd8192;
            endcase
         end
      endcase
   endfunction

   // Drive rsp ready: random stalls after each word and at random idle cycles
   initial begin : drive_sink
      int hold;
      hold = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_if.ready <= 1'b0;
         end else if (hold > 0) begin
            hold--;
            rsp_if.ready <= (hold == 0);
         end else if (rsp_if.valid && rsp_if.ready) begin
            hold = sink_calm ? 0 : $urandom_range(0, 6);
            rsp_if.ready <= (hold == 0);
         end else begin
            rsp_if.ready <= sink_calm || ($urandom_range(0, 3) != 0);
         end
      end
   end

   // Compare each returned word with the oldest expectation
   always @(posedge clock) begin : watch_results
      out_frame_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         words_out++;
         if (pending.size() == 0) begin
            $display("%0t: unexpected word left=%0d right=%0d last=%0b", $time,
                     rsp_if.left_out, rsp_if.right_out, rsp_if.run_last);
            errors++;
         end else begin
            want = pending.pop_front();
            if (rsp_if.left_out !== want.left || rsp_if.right_out !== want.right ||
                rsp_if.run_last !== want.last) begin
               $display("%0t: expected left=%0d right=%0d last=%0b, %s",
                        $time, want.left, want.right, want.last, "actual below");
               $display("%0t: got left=%0d right=%0d last=%0b",
                        $time, rsp_if.left_out, rsp_if.right_out, rsp_if.run_last);
               errors++;
            end
         end
      end
   end

   initial begin : run_limit
      #1_000_000;
      $display("Some tests failed");
      $finish;
   end

   initial begin : main
      row_type     plan[$];
      row_type     row;
      int          phase_no;
      int          rand_frames;
      logic [31:0] step_val;

      errors      = 0;
      words_in    = 0;
      words_out   = 0;
      restarts    = 0;
      step_writes = 0;
      predicted   = 0;
      sender_calm = 1'b0;
      sink_calm   = 1'b0;
      model_step   = STEP_W'(PHASE_ONE);
      model_phase  = '0;
      model_hist_l = '0;
      model_hist_r = '0;

      reset               <= 1'b1;
      req_if.valid        <= 1'b0;
      req_if.left_sample  <= '0;
      req_if.right_sample <= '0;
      req_if.restart      <= 1'b0;
      csr_psel            <= 1'b0;
      csr_penable         <= 1'b0;
      csr_pwrite          <= 1'b0;
      csr_paddr           <= '0;
      csr_pwdata          <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      csr_check_step();

      // At unit step each word returns the previous word, so those rows are typed in
      plan.push_back('{ROW_TYPED, 32'd0, STEP_ADDR, 16'sd100, -16'sd100, 1'b0, 16'sd0, 16'sd0});
      plan.push_back('{ROW_TYPED, 32'd0, STEP_ADDR, S_MAX, S_MIN, 1'b0, 16'sd100, -16'sd100});
      plan.push_back('{ROW_TYPED, 32'd0, STEP_ADDR, S_MIN, S_MAX, 1'b0, S_MAX, S_MIN});
      plan.push_back('{ROW_TYPED, 32'd0, STEP_ADDR, 16'sd0, 16'sd0, 1'b0, S_MIN, S_MAX});
      plan.push_back('{ROW_TYPED, 32'd0, STEP_ADDR, 16'sd1234, 16'sd5678, 1'b1, 16'sd0, 16'sd0});
      plan.push_back('{ROW_TYPED, 32'd0, STEP_ADDR, -16'sd1, -16'sd1, 1'b0, 16'sd1234, 16'sd5678});
      // half step: two words out per word in; restart must keep the step
      plan.push_back('{ROW_WRITE, 32'h8000, STEP_ADDR, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0});
      plan.push_back('{ROW_FRAME, 32'd0, STEP_ADDR, S_MAX, S_MIN, 1'b0, 16'sd0, 16'sd0});
      plan.push_back('{ROW_FRAME, 32'd0, STEP_ADDR, S_MIN, S_MAX, 1'b0, 16'sd0, 16'sd0});
      plan.push_back('{ROW_FRAME, 32'd0, STEP_ADDR, 16'sd5, -16'sd5, 1'b1, 16'sd0, 16'sd0});
      plan.push_back('{ROW_FRAME, 32'd0, STEP_ADDR, 16'sd9, 16'sd9, 1'b0, 16'sd0, 16'sd0});
      // smallest legal step: run fills the cap exactly
      plan.push_back('{ROW_WRITE, 32'd8192, STEP_ADDR, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0});
      plan.push_back('{ROW_FRAME, 32'd0, STEP_ADDR, S_MAX, S_MIN, 1'b0, 16'sd0, 16'sd0});
      plan.push_back('{ROW_FRAME, 32'd0, STEP_ADDR, S_MIN, S_MAX, 1'b0, 16'sd0, 16'sd0});
      // zero step and a tiny one: cap hit with the phase still below one
      plan.push_back('{ROW_WRITE, 32'd0, STEP_ADDR, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0});
      plan.push_back('{ROW_FRAME, 32'd0, STEP_ADDR, 16'sd1000, -16'sd1000, 1'b0, 16'sd0, 16'sd0});
      plan.push_back('{ROW_FRAME, 32'd0, STEP_ADDR, S_MIN, S_MAX, 1'b0, 16'sd0, 16'sd0});
      plan.push_back('{ROW_WRITE, 32'd1000, STEP_ADDR, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0});
      plan.push_back('{ROW_FRAME, 32'd0, STEP_ADDR, 16'sd7, 16'sd8, 1'b0, 16'sd0, 16'sd0});
      // largest step: most words yield nothing
      plan.push_back('{ROW_WRITE, 32'h3ffff, STEP_ADDR, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0});
      plan.push_back('{ROW_FRAME, 32'd0, STEP_ADDR, 16'sh5555, 16'shaaaa, 1'b0, 16'sd0, 16'sd0});
      plan.push_back('{ROW_FRAME, 32'd0, STEP_ADDR, 16'shaaaa, 16'sh5555, 1'b0, 16'sd0, 16'sd0});
      plan.push_back('{ROW_FRAME, 32'd0, STEP_ADDR, -16'sd1, 16'sd0, 1'b0, 16'sd0, 16'sd0});
      plan.push_back('{ROW_FRAME, 32'd0, STEP_ADDR, S_MAX, S_MAX, 1'b0, 16'sd0, 16'sd0});
      // write past the last register is dropped
      plan.push_back('{ROW_WRITE, 32'h10000, SPARE_ADDR, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0});
      plan.push_back('{ROW_FRAME, 32'd0, STEP_ADDR, 16'sd3, 16'sd4, 1'b0, 16'sd0, 16'sd0});
      // bits above the step width are ignored
      plan.push_back('{ROW_WRITE, 32'hfffd8000, STEP_ADDR, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0});
      plan.push_back('{ROW_FRAME, 32'd0, STEP_ADDR, S_MAX, S_MAX, 1'b0, 16'sd0, 16'sd0});
      plan.push_back('{ROW_FRAME, 32'd0, STEP_ADDR, S_MIN, S_MIN, 1'b0, 16'sd0, 16'sd0});
      plan.push_back('{ROW_FRAME, 32'd0, STEP_ADDR, 16'sd0, 16'sd0, 1'b1, 16'sd0, 16'sd0});

      // Walk the directed rows
      foreach (plan[i]) begin
         row = plan[i];
         if (row.kind == ROW_WRITE) begin
            settle();
            csr_write(row.addr, row.data);
            csr_check_step();
         end else begin
            push_word(row.left, row.right, row.restart, row.kind == ROW_FRAME);
            if (row.kind == ROW_TYPED)
               pending.push_back(out_frame_type'{row.exp_left, row.exp_right, 1'b1});
         end
      end

      // Random phases: new step, new idling mood, random words
      phase_no    = 0;
      rand_frames = 0;
      while (rand_frames < RANDOM_FRAMES) begin
         settle();
         step_val = pick_step(phase_no);
         csr_write(STEP_ADDR, step_val);
         csr_check_step();
         sender_calm = ($urandom_range(0, 3) == 0);
         sink_calm   = ($urandom_range(0, 3) == 0);
         repeat (PHASE_LEN) begin
            // now and then hold off until the block has drained
            if ($urandom_range(0, 19) == 0) settle();
            push_word(pick_sample(), pick_sample(), $urandom_range(0, 15) == 0, 1'b1);
            rand_frames++;
         end
         phase_no++;
      end

      settle();
      $display("Run covered %0d words in (%0d restarts), %0d of %0d words out, %0d writes.",
               words_in, restarts, words_out, predicted, step_writes);
      $display("Random part ran %0d step settings including zero, the cap and the maximum.",
               phase_no);
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
